// ===== design/rdc_pkg.sv =====
// ---------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and helpers for the radix digit converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int WORD_BITS = 32;
  localparam int VALUE_W   = 32;
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int ADDR_W    = $clog2(WORD_BITS);
  localparam int BITCNT_W  = $clog2(WORD_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(55); // 'A' - 10

  typedef struct packed {
    logic load;      // capture a new word and radix
    logic div_step;  // one restoring-division step
    logic store;     // write remainder to the digit store
    logic rd_en;     // read digit store at the emit index
    logic load_out;  // move read data into the output register
  } rdc_cmd_t;

  typedef struct packed {
    logic div_last;  // final division step of this digit
    logic quo_zero;  // quotient has reached zero
    logic store_full;// digit store is about to be full
    logic idx_zero;  // emit index at least significant digit
    logic out_free;  // output register can take a word
  } rdc_sts_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d <= DIGIT_W'(35)) begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/rdc_ram.sv =====
// ---------------------------------------------------------------------------
// rdc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rdc_datapath.sv =====
// ---------------------------------------------------------------------------
// rdc_datapath
// Bit-serial restoring divider, digit store and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rdc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rdc_pkg::rdc_cmd_t             cmd,
  output      rdc_pkg::rdc_sts_t             sts,
  input  wire logic [rdc_pkg::VALUE_W-1:0]   in_value,
  input  wire logic [rdc_pkg::RADIX_W-1:0]   in_radix,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rdc_pkg::CHAR_W-1:0]    out_digit_char,
  output      logic                          out_last
);

  import rdc_pkg::*;

  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic [BITCNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [ADDR_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic [DIGIT_W:0]     trial;
  logic                 fits;
  logic [DIGIT_W-1:0]   rd_digit;
  logic [RADIX_W-1:0]   radix_clamped;

  always_comb begin
    if (in_radix inside {[RADIX_MIN:RADIX_MAX]}) begin
      radix_clamped = in_radix;
    end else if (in_radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else begin
      radix_clamped = RADIX_MAX;
    end
  end

  // shift in next dividend bit and try to subtract the radix
  assign trial = {rem_r, quo_r[WORD_BITS-1]};
  assign fits  = trial >= {1'b0, radix_r};

  always_comb begin
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      quo_nxt     = WORD_BITS'(in_value);
      rem_nxt     = '0;
      radix_nxt   = radix_clamped;
      bit_cnt_nxt = '0;
      cnt_nxt     = '0;
    end
    if (cmd.div_step) begin
      quo_nxt     = {quo_r[WORD_BITS-2:0], fits};
      rem_nxt     = fits ? DIGIT_W'(trial - {1'b0, radix_r}) : trial[DIGIT_W-1:0];
      bit_cnt_nxt = bit_cnt_r + BITCNT_W'(1);
    end
    if (cmd.store) begin
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      cnt_nxt     = cnt_r + ADDR_W'(1);
      idx_nxt     = cnt_r;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r   <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bit_cnt_r   <= bit_cnt_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    if (cmd.load_out) begin
      out_char_r <= digit_glyph(rd_digit);
      out_last_r <= (idx_r == '0);
    end
  end

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (WORD_BITS)
  ) u_digit_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (cnt_r),
    .wr_data (rem_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_digit)
  );

  assign sts.div_last   = (bit_cnt_r == BITCNT_W'(WORD_BITS - 1));
  assign sts.quo_zero   = (quo_r == '0);
  assign sts.store_full = (cnt_r == ADDR_W'(WORD_BITS - 1));
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== design/rdc_ctrl.sv =====
// ---------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: divide per digit, store remainders, then read them back in
// reverse order into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire rdc_pkg::rdc_sts_t sts,
  output      rdc_pkg::rdc_cmd_t cmd
);

  import rdc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        // stop when the quotient is gone or the store is full
        if (sts.quo_zero || sts.store_full) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_EMIT: begin
        // hold the read until the output register has room
        if (sts.out_free) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = sts.idx_zero ? S_IDLE : S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ===== design/radix_digit_converter_top.sv =====
// ---------------------------------------------------------------------------
// radix_digit_converter_top
// Converts an unsigned word to ASCII digits in radix 2..36, MSD first.
// ---------------------------------------------------------------------------
// One word in, one output word per digit character ('0'-'9', 'A'-'Z'), most
// significant first, with out_last on the final character; zero gives a
// single '0' and the radix is clamped to 2..36. Digits come from a
// one-bit-per-cycle restoring divider: each digit is divided out over the
// whole word and its remainder written to the digit store, and each
// character is then read back from the digit store into the output
// register, each read held until the output register has room. One word
// is converted at a time; the next is accepted while the last character
// still waits at the output.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [rdc_pkg::VALUE_W-1:0] in_value,
  input  wire logic [rdc_pkg::RADIX_W-1:0] in_radix,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [rdc_pkg::CHAR_W-1:0]  out_digit_char,
  output      logic                        out_last
);

  import rdc_pkg::*;

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/radix_digit_converter_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radix_digit_converter_top_test
// Sends words with a radix to the digit converter and checks each character
// that comes back, in order. Expected characters come from a short directed
// table and from a local digit predictor. Both sides of the handshake idle
// at random, with one stretch where neither side idles.
// ---------------------------------------------------------------------------

module radix_digit_converter_top_test;

  localparam int QUIET_LIMIT   = 8000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_WORDS  = 238;
  localparam int MAX_REPORTS   = 60;
  localparam int DIRECTED_ROWS = 22;

  localparam logic [5:0] RADIX_LO = 6'd2;
  localparam logic [5:0] RADIX_HI = 6'd36;
  localparam logic [rdc_pkg::CHAR_W-1:0] GLYPH_DIGIT  = 7'd48; // '0'
  localparam logic [rdc_pkg::CHAR_W-1:0] GLYPH_LETTER = 7'd55; // 'A' - 10

  typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] glyph;
    logic                       last;
  } char_word_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic [rdc_pkg::VALUE_W-1:0]    in_value  = '0;
  logic [rdc_pkg::RADIX_W-1:0]    in_radix  = '0;
  logic                           out_ready = 1'b0;
  logic                           in_ready;
  logic                           out_valid;
  logic [rdc_pkg::CHAR_W-1:0]     out_digit_char;
  logic                           out_last;

  char_word_t expected_chars[$];
  int         error_count  = 0;
  int         quiet_cycles = 0;
  bit         calm         = 1'b0;

  logic [31:0] dir_value [DIRECTED_ROWS] = '{
    32'd0, 32'd0, 32'd0, 32'd1,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'd35, 32'd36, 32'd5, 32'd5, 32'd35, 32'd35,
    32'h8000_0000, 32'hDEAD_BEEF, 32'd10, 32'd9, 32'd1000,
    32'h7FFF_FFFF, 32'd12345678, 32'd1
  };
  logic [5:0] dir_radix [DIRECTED_ROWS] = '{
    6'd10, 6'd0, 6'd63, 6'd2,
    6'd2, 6'd16, 6'd10, 6'd36,
    6'd36, 6'd36, 6'd0, 6'd1, 6'd37, 6'd63,
    6'd2, 6'd16, 6'd11, 6'd10, 6'd10,
    6'd3, 6'd8, 6'd63
  };
  // empty text: expectation comes from the predictor
  string dir_text [DIRECTED_ROWS] = '{
    "0", "0", "0", "1",
    {"11111111", "11111111", "11111111", "11111111"}, "FFFFFFFF", "4294967295", "",
    "Z", "10", "101", "101", "Z", "Z",
    "", "DEADBEEF", "A", "9", "1000",
    "", "", "1"
  };

  radix_digit_converter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // Divide repeatedly, then queue the characters most significant first.
  function automatic void predict_digits(input logic [31:0] value, input logic [5:0] radix);
    logic [5:0]  digits [32];
    logic [31:0] rest;
    logic [31:0] base;
    char_word_t  w;
    int          n;
    if (radix < RADIX_LO) base = 32'(RADIX_LO);
    else if (radix > RADIX_HI) base = 32'(RADIX_HI);
    else base = 32'(radix);
    rest = value;
    n = 0;
    do begin
      digits[n] = 6'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      w.glyph = (digits[k] < 6'd10) ? GLYPH_DIGIT + 7'(digits[k])
                                    : GLYPH_LETTER + 7'(digits[k]);
      w.last  = (k == 0);
      expected_chars.push_back(w);
    end
  endfunction

  function automatic void expect_text(input string txt);
    char_word_t w;
    byte        c;
    for (int i = 0; i < txt.len(); i++) begin
      c = txt[i];
      w.glyph = c[6:0];
      w.last  = (i == txt.len() - 1);
      expected_chars.push_back(w);
    end
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom();
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [5:0] pick_radix();
    if ($urandom_range(9) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(36, 2));
  endfunction

  // Leave valid high on return; the next word or a pause decides its level.
  task automatic send_word(input logic [31:0] value, input logic [5:0] radix,
                           input string txt);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_radix <= radix;
    do @(posedge clk); while (!in_ready);
    if (txt.len() != 0) expect_text(txt);
    else predict_digits(value, radix);
  endtask

  task automatic wait_for_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(dir_value[i], dir_radix[i], dir_text[i]);
    end
    wait_for_empty();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 120 && i < 170);
      if (i == 60) wait_for_empty();
      send_word(pick_value(), pick_radix(), "");
    end
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("radix_digit_converter_top_test: clean");
    end else begin
      $display("radix_digit_converter_top_test: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= !take_break();
  end

  always @(posedge clk) begin : char_check
    char_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word char %0d last %0b",
                                  out_digit_char, out_last));
      end else begin
        want = expected_chars.pop_front();
        if (out_digit_char !== want.glyph) begin
          report_mismatch($sformatf("char got %0d want %0d", out_digit_char, want.glyph));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
        end
      end
    end
  end

  // Count cycles with no word moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("radix_digit_converter_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
